// ----- sv/tes_pkg.sv -----
// shared types and codes of the timed event scheduler
package tes_pkg;

  localparam int TIME_W     = 32;
  localparam int HANDLE_W   = 16;
  localparam int RESULT_CAP = 17;
  localparam int NRES_W     = $clog2(RESULT_CAP + 1);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_START    = 2'd1;
  localparam logic [1:0] KIND_USER     = 2'd2;
  localparam logic [1:0] KIND_PERIODIC = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BUSY = 2'd2;

  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_READ,
    S_ADD_CMP,
    S_ADD_PUT,
    S_TICK_READ,
    S_TICK_EVAL,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]   tstamp;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   tstamp;
    logic [1:0]          status;
    logic                done_flag;
  } res_t;

endpackage

// ----- sv/timed_event_scheduler.sv -----
// timed event scheduler: sorted event table in memory with tick driven firing
//
// command channel (cmd_valid / cmd_stall) takes add, start and tick words;
// result channel (res_valid / res_stall) gives one word per result, with last
// set on the final word of each command. registers period_ms (0x0) and
// periodic_base (0x4) sit on the apb port.
// the event table is one memory of MAX_EVENTS slots, one read and one write a
// cycle, read data registered. an add walks the table from its tail, one slot
// a cycle, shifting later events up. a tick reads the next user slot and fires
// in time order, up to 17 results.
// one command is worked on at a time; cmd_stall is high until the last word
// of the current command has entered the output register.
// a stalled result holds in the output register and the next result waits in
// a holding register, so the walk pauses until the receiver takes words.
// reset empties the table, stops the run and sets the interval to 1000 ms.
module timed_event_scheduler import tes_pkg::*; #(
  parameter int MAX_EVENTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [1:0]          command,
  input  logic [TIME_W-1:0]   event_time,
  input  logic [HANDLE_W-1:0] event_handle,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [1:0]          kind,
  output logic [HANDLE_W-1:0] handle_out,
  output logic [TIME_W-1:0]   fire_time,
  output logic [1:0]          status,
  output logic                done_res,
  output logic                last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_EVENTS + 1);

  state_t state, state_next;

  slot_t mem [MAX_EVENTS];
  slot_t rd_word;
  logic [AW-1:0] rd_addr, mem_wa;
  logic mem_we;
  slot_t mem_wd;

  logic [TIME_W-1:0] period_ms, periodic_base;
  logic [CW-1:0] stored_count, stored_count_next;
  logic [CW-1:0] next_slot, next_slot_next;
  logic [TIME_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [TIME_W-1:0] periodic_last, periodic_last_next;
  logic running, running_next;
  logic [AW-1:0] idx, idx_next;
  slot_t add_word, add_word_next;
  res_t pend, pend_next;
  logic pend_valid, pend_valid_next;
  logic per_done, per_done_next;
  logic [NRES_W-1:0] n_res, n_res_next;

  logic push, push_last;
  logic out_free, cmd_accept, can_emit, slot_end;
  logic [TIME_W-1:0] iv, pt;
  logic [TIME_W:0] per_sum;
  logic pv;
  logic [CW-1:0] next_slot_inc;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign out_free   = !res_valid || !res_stall;
  assign can_emit   = !pend_valid || out_free;

  assign iv      = (period_ms == '0) ? TIME_W'(1) : period_ms;
  assign per_sum = {1'b0, periodic_last} + {1'b0, iv};
  assign pv      = !per_sum[TIME_W];
  assign pt      = per_sum[TIME_W-1:0];
  assign next_slot_inc = next_slot + 1'b1;
  assign slot_end      = (next_slot_inc >= stored_count);

  assign pready = 1'b1;
  assign prdata = paddr[2] ? periodic_base : period_ms;

  always_comb begin
    case (state)
      S_ADD_READ: rd_addr = idx;
      S_ADD_CMP:  rd_addr = idx - 1'b1;
      default:    rd_addr = next_slot[AW-1:0];
    endcase
  end

  // event table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    stored_count_next  = stored_count;
    next_slot_next     = next_slot;
    elapsed_ms_next    = elapsed_ms;
    periodic_last_next = periodic_last;
    running_next       = running;
    idx_next           = idx;
    add_word_next      = add_word;
    pend_next          = pend;
    pend_valid_next    = pend_valid;
    per_done_next      = per_done;
    n_res_next         = n_res;
    push               = 1'b0;
    push_last          = 1'b0;
    mem_we             = 1'b0;
    mem_wa             = '0;
    mem_wd             = add_word;

    case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          case (command)
            CMD_ADD: begin
              add_word_next   = '{tstamp: event_time, handle: event_handle};
              pend_next       = '{KIND_ADD, '0, '0, STATUS_OK, 1'b0};
              pend_valid_next = 1'b1;
              state_next      = S_FLUSH;
              if (running) begin
                pend_next.status = STATUS_BUSY;
              end else if (stored_count >= CW'(MAX_EVENTS)) begin
                pend_next.status = STATUS_FULL;
              end else if (stored_count == '0) begin
                mem_we            = 1'b1;
                mem_wa            = '0;
                mem_wd            = '{tstamp: event_time, handle: event_handle};
                stored_count_next = stored_count + 1'b1;
              end else begin
                idx_next   = AW'(stored_count - 1'b1);
                state_next = S_ADD_READ;
              end
            end
            CMD_START: begin
              pend_next       = '{KIND_START, '0, '0, STATUS_OK, 1'b0};
              pend_valid_next = 1'b1;
              state_next      = S_FLUSH;
              if (running) begin
                pend_next.status = STATUS_BUSY;
              end else if (stored_count == '0) begin
                pend_next.done_flag = 1'b1;
              end else begin
                running_next       = 1'b1;
                elapsed_ms_next    = '0;
                next_slot_next     = '0;
                periodic_last_next = periodic_base;
              end
            end
            CMD_TICK: begin
              if (running) begin
                if (elapsed_ms != '1) begin
                  elapsed_ms_next = elapsed_ms + 1'b1;
                end
                per_done_next   = 1'b0;
                n_res_next      = '0;
                pend_valid_next = 1'b0;
                state_next      = S_TICK_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_READ: begin
        state_next = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        mem_we = 1'b1;
        mem_wa = idx + 1'b1;
        if (rd_word.tstamp > add_word.tstamp) begin
          mem_wd = rd_word;
          if (idx == '0) begin
            state_next = S_ADD_PUT;
          end else begin
            idx_next = idx - 1'b1;
          end
        end else begin
          stored_count_next = stored_count + 1'b1;
          state_next        = S_FLUSH;
        end
      end
      S_ADD_PUT: begin
        mem_we            = 1'b1;
        mem_wa            = '0;
        stored_count_next = stored_count + 1'b1;
        state_next        = S_FLUSH;
      end
      S_TICK_READ: begin
        state_next = S_TICK_EVAL;
      end
      S_TICK_EVAL: begin
        if (!running || n_res >= NRES_W'(RESULT_CAP) || next_slot >= stored_count) begin
          state_next = S_FLUSH;
        end else if (pv && pt <= rd_word.tstamp) begin
          if (per_done || pt > elapsed_ms) begin
            state_next = S_FLUSH;
          end else if (can_emit) begin
            push               = pend_valid;
            pend_next          = '{KIND_PERIODIC, '0, pt, STATUS_OK, 1'b0};
            pend_valid_next    = 1'b1;
            n_res_next         = n_res + 1'b1;
            periodic_last_next = pt;
            per_done_next      = 1'b1;
          end
        end else begin
          if (rd_word.tstamp > elapsed_ms) begin
            state_next = S_FLUSH;
          end else if (can_emit) begin
            push            = pend_valid;
            pend_next       = '{KIND_USER, rd_word.handle, rd_word.tstamp, STATUS_OK,
                                slot_end};
            pend_valid_next = 1'b1;
            n_res_next      = n_res + 1'b1;
            next_slot_next  = next_slot_inc;
            if (slot_end) begin
              running_next = 1'b0;
            end
            state_next = S_TICK_READ;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms     <= INTERVAL_RESET;
      periodic_base <= '0;
      stored_count  <= '0;
      next_slot     <= '0;
      elapsed_ms    <= '0;
      periodic_last <= '0;
      running       <= 1'b0;
      pend_valid    <= 1'b0;
      per_done      <= 1'b0;
      n_res         <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2]) begin
          periodic_base <= pwdata;
        end else begin
          period_ms <= pwdata;
        end
      end
      stored_count  <= stored_count_next;
      next_slot     <= next_slot_next;
      elapsed_ms    <= elapsed_ms_next;
      periodic_last <= periodic_last_next;
      running       <= running_next;
      pend_valid    <= pend_valid_next;
      per_done      <= per_done_next;
      n_res         <= n_res_next;
      if (push) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    add_word <= add_word_next;
    pend     <= pend_next;
    if (push) begin
      kind       <= pend.kind;
      handle_out <= pend.handle;
      fire_time  <= pend.tstamp;
      status     <= pend.status;
      done_res   <= pend.done_flag;
      last       <= push_last;
    end
  end

endmodule

// ----- sv/tes_checker.sv -----
// port level checks of the timed event scheduler and their binding
module tes_checker import tes_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input logic [1:0]          kind,
  input logic [HANDLE_W-1:0] handle_out,
  input logic [TIME_W-1:0]   fire_time,
  input logic [1:0]          status,
  input logic                done_res,
  input logic                last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(handle_out) &&
      $stable(fire_time) && $stable(status) && $stable(done_res) && $stable(last))
    else $error("stalled result word changed");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_USER || kind == KIND_PERIODIC) |-> status == STATUS_OK)
    else $error("fired word with nonzero status");

  a_reply: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_ADD || kind == KIND_START) |->
      last && handle_out == '0 && fire_time == '0)
    else $error("reply word malformed");

  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> last && (kind == KIND_USER || kind == KIND_START))
    else $error("run end flagged on wrong word");

endmodule

bind timed_event_scheduler tes_checker u_tes_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .kind       (kind),
  .handle_out (handle_out),
  .fire_time  (fire_time),
  .status     (status),
  .done_res   (done_res),
  .last       (last)
);

// ----- test/timed_event_scheduler_check.sv -----
// result checker for the timed event scheduler: predicts every result word and compares it
`timescale 1ns / 100ps

module timed_event_scheduler_check import tes_pkg::*; #(
  parameter int         MAX_EVENTS    = 16,
  parameter logic [2:0] INTERVAL_ADDR = 3'd0,
  parameter logic [2:0] BASE_ADDR     = 3'd4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_stall,
  input  logic [1:0]          command,
  input  logic [TIME_W-1:0]   event_time,
  input  logic [HANDLE_W-1:0] event_handle,
  input  logic                res_valid,
  input  logic                res_stall,
  input  logic [1:0]          kind,
  input  logic [HANDLE_W-1:0] handle_out,
  input  logic [TIME_W-1:0]   fire_time,
  input  logic [1:0]          status,
  input  logic                done_res,
  input  logic                last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  words_due
);

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   tstamp;
    logic [1:0]          status;
    logic                done_flag;
    logic                last_flag;
  } word_t;

  logic [TIME_W-1:0]   ev_time   [MAX_EVENTS];
  logic [HANDLE_W-1:0] ev_handle [MAX_EVENTS];
  int                  fill;
  int                  cursor;
  logic [TIME_W-1:0]   clock_ms;
  logic [TIME_W-1:0]   last_sample;
  logic [TIME_W-1:0]   interval_ms;
  logic [TIME_W-1:0]   base_ms;
  logic                active;
  word_t               due_words [$];

  function automatic word_t make_word(input logic [1:0] k, input logic [HANDLE_W-1:0] h,
                                      input logic [TIME_W-1:0] t, input logic [1:0] s,
                                      input logic d);
    word_t w;
    w.kind      = k;
    w.handle    = h;
    w.tstamp    = t;
    w.status    = s;
    w.done_flag = d;
    w.last_flag = 1'b0;
    return w;
  endfunction

  task automatic predict_words(input logic [1:0] op, input logic [TIME_W-1:0] at,
                               input logic [HANDLE_W-1:0] id);
    int                pos;
    int                n;
    logic              took_periodic;
    logic              stop;
    logic              sample_ok;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] sample_at;
    logic [TIME_W-1:0] user_at;
    word_t             w;
    n = 0;
    case (op)
      CMD_ADD: begin
        if (active) begin
          due_words.push_back(make_word(KIND_ADD, '0, '0, STATUS_BUSY, 1'b0));
        end else if (fill >= MAX_EVENTS) begin
          due_words.push_back(make_word(KIND_ADD, '0, '0, STATUS_FULL, 1'b0));
        end else begin
          pos = 0;
          while (pos < fill && ev_time[pos] <= at) pos++;
          for (int i = fill; i > pos; i--) begin
            ev_time[i]   = ev_time[i-1];
            ev_handle[i] = ev_handle[i-1];
          end
          ev_time[pos]   = at;
          ev_handle[pos] = id;
          fill++;
          due_words.push_back(make_word(KIND_ADD, '0, '0, STATUS_OK, 1'b0));
        end
        n = 1;
      end
      CMD_START: begin
        if (active) begin
          due_words.push_back(make_word(KIND_START, '0, '0, STATUS_BUSY, 1'b0));
        end else if (fill == 0) begin
          due_words.push_back(make_word(KIND_START, '0, '0, STATUS_OK, 1'b1));
        end else begin
          active      = 1'b1;
          clock_ms    = '0;
          cursor      = 0;
          last_sample = base_ms;
          due_words.push_back(make_word(KIND_START, '0, '0, STATUS_OK, 1'b0));
        end
        n = 1;
      end
      CMD_TICK: begin
        if (active) begin
          took_periodic = 1'b0;
          stop          = 1'b0;
          step          = (interval_ms == '0) ? 32'd1 : interval_ms;
          if (clock_ms != '1) clock_ms = clock_ms + 32'd1;
          while (!stop && active && n < RESULT_CAP && cursor < fill) begin
            sample_ok = (last_sample <= ~step);
            sample_at = last_sample + step;
            user_at   = ev_time[cursor];
            if (sample_ok && sample_at <= user_at) begin
              if (took_periodic || sample_at > clock_ms) begin
                stop = 1'b1;
              end else begin
                last_sample   = sample_at;
                took_periodic = 1'b1;
                due_words.push_back(make_word(KIND_PERIODIC, '0, sample_at, STATUS_OK, 1'b0));
                n++;
              end
            end else if (user_at > clock_ms) begin
              stop = 1'b1;
            end else begin
              cursor++;
              due_words.push_back(make_word(KIND_USER, ev_handle[cursor-1], user_at,
                                            STATUS_OK, cursor >= fill));
              n++;
              if (cursor >= fill) active = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      w = due_words.pop_back();
      w.last_flag = 1'b1;
      due_words.push_back(w);
    end
  endtask

  task automatic note_miss(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s expected %h got %h", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_word();
    word_t want;
    if (due_words.size() == 0) begin
      $display("%0t: unexpected word kind %0d handle %h time %h", $time, kind, handle_out,
               fire_time);
      mismatches++;
    end else begin
      want = due_words.pop_front();
      if (kind !== want.kind) note_miss("kind", 32'(want.kind), 32'(kind));
      if (handle_out !== want.handle) begin
        note_miss("handle_out", 32'(want.handle), 32'(handle_out));
      end
      if (fire_time !== want.tstamp) note_miss("fire_time", want.tstamp, fire_time);
      if (status !== want.status) note_miss("status", 32'(want.status), 32'(status));
      if (done_res !== want.done_flag) begin
        note_miss("done_res", 32'(want.done_flag), 32'(done_res));
      end
      if (last !== want.last_flag) note_miss("last", 32'(want.last_flag), 32'(last));
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      fill        = 0;
      cursor      = 0;
      clock_ms    = '0;
      last_sample = '0;
      active      = 1'b0;
      interval_ms = INTERVAL_RESET;
      base_ms     = '0;
      mismatches  = 0;
      due_words.delete();
    end else begin
      if (res_valid && !res_stall) check_word();
      if (psel && penable && pwrite && pready) begin
        if (paddr == INTERVAL_ADDR) interval_ms = pwdata;
        else if (paddr == BASE_ADDR) base_ms = pwdata;
      end
      if (cmd_valid && !cmd_stall) predict_words(command, event_time, event_handle);
    end
    words_due = due_words.size();
  end

endmodule

// ----- test/timed_event_scheduler_test.sv -----
// testbench top for the timed event scheduler: stimulus, flow control and verdict
`timescale 1ns / 100ps

module timed_event_scheduler_test;
  import tes_pkg::*;

  localparam int         MAX_EVENTS    = 16;
  localparam logic [2:0] INTERVAL_ADDR = 3'd0;
  localparam logic [2:0] BASE_ADDR     = 3'd4;
  localparam logic [1:0] CMD_UNKNOWN   = 2'd3;
  localparam int         ITEM_TARGET   = 310;
  localparam int         TAIL_ITEMS    = 40;
  localparam int         DRAIN_CYCLES  = 60;
  localparam int         LONG_HOLD     = 300;
  localparam int         QUIET_LIMIT   = 4000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cmd_valid    = 1'b0;
  logic                cmd_stall;
  logic [1:0]          command      = CMD_TICK;
  logic [TIME_W-1:0]   event_time   = '0;
  logic [HANDLE_W-1:0] event_handle = '0;
  logic                res_valid;
  logic                res_stall    = 1'b0;
  logic [1:0]          kind;
  logic [HANDLE_W-1:0] handle_out;
  logic [TIME_W-1:0]   fire_time;
  logic [1:0]          status;
  logic                done_res;
  logic                last;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [2:0]          paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  mismatches;
  int                  words_due;

  int                  items         = 0;
  int                  send_idle_pct = 20;
  int                  recv_idle_pct = 63;
  int                  hold_asks     = 0;
  int                  hold_seen     = 0;
  int                  hold_left     = 0;
  int                  quiet_cycles  = 0;
  int                  table_fill    = 0;
  logic [TIME_W-1:0]   table_latest  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timed_event_scheduler #(.MAX_EVENTS(MAX_EVENTS)) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .event_time(event_time), .event_handle(event_handle),
    .res_valid(res_valid), .res_stall(res_stall),
    .kind(kind), .handle_out(handle_out), .fire_time(fire_time),
    .status(status), .done_res(done_res), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  timed_event_scheduler_check #(
    .MAX_EVENTS(MAX_EVENTS), .INTERVAL_ADDR(INTERVAL_ADDR), .BASE_ADDR(BASE_ADDR)
  ) checker_i (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .event_time(event_time), .event_handle(event_handle),
    .res_valid(res_valid), .res_stall(res_stall),
    .kind(kind), .handle_out(handle_out), .fire_time(fire_time),
    .status(status), .done_res(done_res), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .words_due(words_due)
  );

  // result side: random stall, or a long hold when asked
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timed_event_scheduler_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [TIME_W-1:0] at,
                           input logic [HANDLE_W-1:0] id);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid    <= 1'b1;
    command      <= op;
    event_time   <= at;
    event_handle <= id;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !cmd_stall;
      @(posedge clk);
    end
    items++;
  endtask

  task automatic add_event(input logic [TIME_W-1:0] at, input logic [HANDLE_W-1:0] id);
    send_word(CMD_ADD, at, id);
    if (table_fill < MAX_EVENTS) begin
      table_fill++;
      if (at > table_latest) table_latest = at;
    end
  endtask

  // start, then tick until the latest event has fired, with rejected words mixed in when noisy is set
  task automatic run_table(input logic noisy);
    int span;
    span = (table_latest == '0) ? 1 : int'(table_latest);
    send_word(CMD_START, $urandom, 16'($urandom));
    if (table_fill != 0) begin
      for (int k = 0; k <= span; k++) begin
        if (noisy && k < span && $urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0: send_word(CMD_ADD, $urandom, 16'($urandom));
            1: send_word(CMD_ADD, '1, '0);
            2: send_word(CMD_START, $urandom, 16'($urandom));
            default: send_word(CMD_UNKNOWN, $urandom, 16'($urandom));
          endcase
        end
        send_word(CMD_TICK, $urandom, 16'($urandom));
      end
    end
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] interval, input logic [31:0] base);
    settle();
    reg_write(INTERVAL_ADDR, interval);
    reg_write(BASE_ADDR, base);
  endtask

  initial begin
    int          runs;
    logic [31:0] iv;
    logic [31:0] bs;
    runs = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_TICK, '0, '0);
    send_word(CMD_UNKNOWN, '1, '1);
    send_word(CMD_START, '0, '0);
    set_config(32'd1, 32'd0);
    add_event(32'd0, 16'hFFFF);
    add_event(32'd3, 16'h0000);
    add_event(32'd3, 16'h1234);
    add_event(32'd1, 16'h00FF);
    add_event(32'd2, 16'h5A5A);
    send_word(CMD_START, '0, '0);
    send_word(CMD_ADD, '1, '1);
    send_word(CMD_START, '1, '1);
    repeat (4) send_word(CMD_TICK, '0, '0);
    set_config(32'd0, 32'd2);
    run_table(1'b0);
    set_config('1, '1);
    run_table(1'b0);

    while (items < ITEM_TARGET - TAIL_ITEMS) begin
      if (items < ITEM_TARGET / 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 63;
      end else if (items < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: iv = 32'd0;
          1: iv = 32'd1;
          2: iv = $urandom_range(2, 6);
          3: iv = $urandom_range(7, 30);
          4: iv = '1;
          default: iv = $urandom;
        endcase
        case ($urandom_range(0, 4))
          0: bs = 32'd0;
          1: bs = $urandom_range(0, 20);
          2: bs = 32'hFFFF_FFF0 | $urandom_range(0, 15);
          3: bs = '1;
          default: bs = $urandom;
        endcase
        set_config(iv, bs);
      end
      repeat ($urandom_range(0, 3)) add_event($urandom_range(0, 24), 16'($urandom));
      if ($urandom_range(0, 3) == 0) send_word(CMD_TICK, $urandom, 16'($urandom));
      if (runs == 1) hold_asks++;
      run_table(1'b1);
      runs++;
    end

    while (table_fill < MAX_EVENTS) add_event($urandom_range(0, 24), 16'($urandom));
    add_event('1, '1);
    set_config(32'd2, 32'd0);
    run_table(1'b1);

    settle();
    if (mismatches == 0 && words_due == 0) begin
      $display("timed_event_scheduler_test OK");
    end else begin
      $display("timed_event_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule
